// ----- rtl/qsp_pkg.sv -----
// Package for the quicksort partition core: field widths, default window depth
// and the packed transfer types of the input and result channels.
// Depends on nothing.
`default_nettype none

package qsp_pkg;

  localparam int KEY_W            = 32;
  localparam int POS_W            = 6;
  localparam int WINDOW_DEPTH_DEF = 64;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             final_key;
  } qsp_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [POS_W-1:0] pivot_position;
    logic             final_result;
  } qsp_out_t;

endpackage

`default_nettype wire

// ----- rtl/qsp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module qsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/quicksort_partition_core.sv -----
// Quicksort partition core: loads a window of keys, partitions it in place around
// its last key in a single RAM and streams the rearranged keys out.
// Depends on qsp_pkg and qsp_ram.
//
//   channel  | ports                     | transfer
//   ---------+---------------------------+--------------------------------------
//   input    | start, busy, in_item      | edge with start high and busy low
//   result   | out_strobe, out_item      | every edge with out_strobe high
//
// Loading accepts a key on every edge with start high and busy low. After the
// flagged key the core partitions the window, scanning and swapping keys through
// the single read and single write port of the key RAM. It then emits one key per
// cycle, the first in the cycle after emission starts; busy stays high from the
// flagged key until the last key has been read.
// Synchronous reset clears only state, key count, output flags; not the key RAM.
// The receiver cannot stall results.
`default_nettype none

module quicksort_partition_core #(
  parameter int WINDOW_DEPTH = qsp_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire qsp_pkg::qsp_in_t in_item,
  output logic                  out_strobe,
  output qsp_pkg::qsp_out_t     out_item
);

  import qsp_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCAN_UP, S_SCAN_DN, S_SWAP, S_UP_NEXT, S_PIVOT, S_PIVOT2, S_EMIT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r;
  logic [AW-1:0]      last_r;
  logic [AW-1:0]      up_r;
  logic signed [AW:0] down_r;
  logic [AW-1:0]      k_r;
  logic [AW-1:0]      pos_r;
  logic [KEY_W-1:0]   pivot_r;
  logic [KEY_W-1:0]   up_key_r;
  logic               emit_v_r;
  logic               emit_last_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;

  logic               accept;
  logic               has_room;
  logic [CW-1:0]      cnt_nxt;
  logic               up_go;
  logic               dn_go;
  logic               crossed;
  logic               down_zero;
  logic [AW-1:0]      up_inc;
  logic [AW-1:0]      down_dec;

  assign accept    = start && !busy;
  assign has_room  = cnt_r < CW'(WINDOW_DEPTH);
  assign cnt_nxt   = has_room ? cnt_r + CW'(1) : cnt_r;
  assign up_go     = (up_r < last_r) && (ram_rdata < pivot_r);
  assign dn_go     = (down_r > 0) && (pivot_r < ram_rdata);
  assign crossed   = $signed({1'b0, up_r}) >= down_r;
  assign down_zero = down_r == 0;
  assign up_inc    = up_r + AW'(1);
  assign down_dec  = AW'(down_r - (AW+1)'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = up_r;
    ram_wdata = pivot_r;
    ram_re    = 1'b0;
    ram_raddr = up_inc;
    unique case (state_r)
      S_IDLE: begin
        ram_we    = accept && has_room;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = in_item.key_value;
      end
      S_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_SCAN_UP: begin
        if (up_go) begin
          ram_re = 1'b1;
        end else begin
          ram_re    = !down_zero;
          ram_raddr = down_dec;
        end
      end
      S_SCAN_DN: begin
        ram_raddr = down_dec;
        if (dn_go) begin
          ram_re = 1'b1;
        end else begin
          ram_we    = !crossed;
          ram_wdata = ram_rdata;
        end
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = down_r[AW-1:0];
        ram_wdata = up_key_r;
      end
      S_UP_NEXT: begin
        ram_re = 1'b1;
      end
      S_PIVOT: begin
        ram_we = 1'b1;
      end
      S_PIVOT2: begin
        ram_we    = 1'b1;
        ram_waddr = last_r;
        ram_wdata = up_key_r;
      end
      S_EMIT: begin
        ram_re    = 1'b1;
        ram_raddr = k_r;
      end
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      emit_v_r    <= state_r == S_EMIT;
      emit_last_r <= (state_r == S_EMIT) && (k_r == last_r);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (has_room) begin
              pivot_r <= in_item.key_value;
            end
            if (in_item.final_key) begin
              last_r  <= AW'(cnt_nxt - CW'(1));
              down_r  <= (AW+1)'(cnt_nxt - CW'(1));
              cnt_r   <= '0;
              state_r <= S_START;
            end else begin
              cnt_r <= cnt_nxt;
            end
          end
        end
        S_START: begin
          up_r    <= '0;
          state_r <= S_SCAN_UP;
        end
        S_SCAN_UP: begin
          if (up_go) begin
            up_r <= up_inc;
          end else begin
            up_key_r <= ram_rdata;
            down_r   <= down_r - (AW+1)'(1);
            state_r  <= down_zero ? S_PIVOT : S_SCAN_DN;
          end
        end
        S_SCAN_DN: begin
          if (dn_go) begin
            down_r <= down_r - (AW+1)'(1);
          end else begin
            state_r <= crossed ? S_PIVOT : S_SWAP;
          end
        end
        S_SWAP: begin
          state_r <= S_UP_NEXT;
        end
        S_UP_NEXT: begin
          up_r    <= up_inc;
          state_r <= S_SCAN_UP;
        end
        S_PIVOT: begin
          pos_r   <= up_r;
          state_r <= S_PIVOT2;
        end
        S_PIVOT2: begin
          k_r     <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          k_r <= k_r + AW'(1);
          if (k_r == last_r) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = emit_v_r;

  always_comb begin
    out_item.sorted_key     = ram_rdata;
    out_item.pivot_position = POS_W'(pos_r);
    out_item.final_result   = emit_last_r;
  end

  qsp_ram #(
    .WIDTH (KEY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- dv/quicksort_partition_core_tb.sv -----
// Self-checking testbench for quicksort_partition_core: sends windows of keys,
// predicts each partitioned window and checks every emitted result in order.
// Depends on qsp_pkg and quicksort_partition_core.
module quicksort_partition_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qsp_pkg::*;

  localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEF;
  localparam int MAX_GAP      = 20;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {KEYS_FULL, KEYS_NARROW, KEYS_EXTREME, KEYS_CLUSTER} key_mix_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  qsp_in_t  in_item;
  logic     out_strobe;
  qsp_out_t out_item;

  logic [KEY_W-1:0] window_keys [WINDOW_DEPTH];
  int unsigned      window_fill;
  qsp_out_t         expected_keys [$];
  qsp_out_t         next_expected;

  int sender_idle_pct;
  int keys_sent;
  int windows_closed;
  int keys_dropped;
  int keys_checked;
  int mismatch_count;

  quicksort_partition_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  task automatic predict_partition(input qsp_in_t item);
    int               last;
    int               up;
    int               down;
    int               k;
    logic [KEY_W-1:0] pivot;
    logic [KEY_W-1:0] tmp;
    qsp_out_t         res;
    if (window_fill < WINDOW_DEPTH) begin
      window_keys[window_fill] = item.key_value;
      window_fill++;
    end else begin
      keys_dropped++;
    end
    if (!item.final_key) return;
    last  = int'(window_fill) - 1;
    pivot = window_keys[last];
    up    = -1;
    down  = last;
    forever begin
      do up++; while (up < last && window_keys[up] < pivot);
      do down--; while (down > 0 && pivot < window_keys[down]);
      if (up >= down) break;
      tmp               = window_keys[up];
      window_keys[up]   = window_keys[down];
      window_keys[down] = tmp;
    end
    tmp               = window_keys[up];
    window_keys[up]   = window_keys[last];
    window_keys[last] = tmp;
    for (k = 0; k <= last; k++) begin
      res.sorted_key     = window_keys[k];
      res.pivot_position = POS_W'(up);
      res.final_result   = (k == last);
      expected_keys.push_back(res);
    end
    window_fill = 0;
    windows_closed++;
  endtask

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic send_key(input logic [KEY_W-1:0] key, input logic last_key);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start             <= 1'b1;
    in_item.key_value <= key;
    in_item.final_key <= last_key;
    do @(posedge clk); while (busy);
    keys_sent++;
    predict_partition('{key_value: key, final_key: last_key});
  endtask

  task automatic send_window(input logic [KEY_W-1:0] keys [$]);
    int i;
    for (i = 0; i < keys.size(); i++) begin
      send_key(keys[i], i == keys.size() - 1);
    end
  endtask

  task automatic test_single_key();
    send_key('0, 1'b1);
    send_key('1, 1'b1);
  endtask

  task automatic test_extreme_keys();
    send_window('{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000});
  endtask

  task automatic test_equal_keys();
    send_window('{32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5});
  endtask

  task automatic test_pivot_lowest();
    send_window('{32'd3, 32'd2, 32'd1, 32'd0});
  endtask

  task automatic test_pivot_highest();
    send_window('{32'd3, 32'd1, 32'd2, 32'hFFFF_FFFF});
  endtask

  task automatic test_window_overflow();
    int i;
    for (i = 0; i < WINDOW_DEPTH + 2; i++) begin
      send_key($urandom, i == WINDOW_DEPTH + 1);
    end
  endtask

  task automatic test_random_windows(input int budget);
    int               sent;
    int               len;
    int               sel;
    int               i;
    key_mix_t         mix;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (sent < budget) begin
      sel = $urandom_range(99);
      if (sel < 55)      len = $urandom_range(8, 1);
      else if (sel < 85) len = $urandom_range(24, 9);
      else if (sel < 95) len = $urandom_range(WINDOW_DEPTH - 1, 25);
      else               len = $urandom_range(WINDOW_DEPTH + 4, WINDOW_DEPTH);
      mix  = key_mix_t'($urandom_range(3));
      base = $urandom;
      for (i = 0; i < len; i++) begin
        case (mix)
          KEYS_FULL:    key = $urandom;
          KEYS_NARROW:  key = $urandom_range(7);
          KEYS_EXTREME: begin
            case ($urandom_range(3))
              0:       key = '0;
              1:       key = '1;
              2:       key = 32'd1;
              default: key = 32'hFFFF_FFFE;
            endcase
          end
          default:      key = base + $urandom_range(15);
        endcase
        send_key(key, i == len - 1);
      end
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected result key=%h pos=%0d last=%b",
                                  out_item.sorted_key, out_item.pivot_position,
                                  out_item.final_result));
      end else begin
        next_expected = expected_keys.pop_front();
        keys_checked++;
        if (out_item.sorted_key !== next_expected.sorted_key ||
            out_item.pivot_position !== next_expected.pivot_position ||
            out_item.final_result !== next_expected.final_result) begin
          report_mismatch($sformatf(
            "result %0d: expected key=%h pos=%0d last=%b, got key=%h pos=%0d last=%b",
            keys_checked, next_expected.sorted_key, next_expected.pivot_position,
            next_expected.final_result, out_item.sorted_key, out_item.pivot_position,
            out_item.final_result));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", expected_keys.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    window_fill     = 0;
    sender_idle_pct = 29;
    keys_sent       = 0;
    windows_closed  = 0;
    keys_dropped    = 0;
    keys_checked    = 0;
    mismatch_count  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_key();
    test_extreme_keys();
    test_equal_keys();
    test_pivot_lowest();
    test_pivot_highest();
    test_window_overflow();
    test_random_windows(60);
    sender_idle_pct = 70;
    test_random_windows(140);
    sender_idle_pct = 0;
    test_random_windows(145);

    start <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d keys in %0d windows (%0d dropped on a full window)",
             keys_sent, windows_closed, keys_dropped);
    $display("Checked %0d partitioned keys, %0d mismatches", keys_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
